### src/mbrc_pkg.sv
// Package for the Modbus-RTU read response checker.
// Holds request and status codes, frame constants, the CRC-16 byte update
// and the result struct. No dependencies.
package mbrc_pkg;

  // Request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_BYTE    = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_HEADER = 2'd2,
    ST_CRC    = 2'd3
  } status_e;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  BYTE_COUNT = 8'h04;
  localparam logic [7:0]  ADDR_RESET = 8'h01;

  // Byte positions in the response frame
  localparam logic [3:0]  IDX_ADDR    = 4'd0;
  localparam logic [3:0]  IDX_FUNC    = 4'd1;
  localparam logic [3:0]  IDX_COUNT   = 4'd2;
  localparam logic [3:0]  IDX_VAL0    = 4'd3;
  localparam logic [3:0]  IDX_VAL3    = 4'd6;
  localparam logic [3:0]  IDX_CRC_LO  = 4'd7;
  localparam logic [3:0]  IDX_CRC_HI  = 4'd8;
  localparam logic [3:0]  CRC_SPAN    = 4'd7;

  // Result produced by one item
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] value;
  } result_t;

  // Reflected CRC-16 update over one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/mbrc_frame.sv
// Frame state of the response checker: byte position, running CRC,
// collected value and header check. Depends on mbrc_pkg.
module mbrc_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  mbrc_pkg::req_e       req_i,
  input  logic [7:0]           byte_i,
  input  logic [7:0]           slave_addr_i,
  output mbrc_pkg::result_t    res_o
);
  import mbrc_pkg::*;

  logic [3:0]  byte_index_q, byte_index_d;
  logic [15:0] crc_q, crc_d;
  logic [31:0] value_q, value_d;
  logic        header_good_q, header_good_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic        closed_q, closed_d;

  logic        hdr_ok;
  logic [15:0] crc_next;

  // Header byte compare at the current position
  always_comb begin
    unique case (byte_index_q)
      IDX_ADDR:  hdr_ok = (byte_i == slave_addr_i);
      IDX_FUNC:  hdr_ok = (byte_i == FUNC_READ);
      IDX_COUNT: hdr_ok = (byte_i == BYTE_COUNT);
      default:   hdr_ok = 1'b1;
    endcase
  end

  assign crc_next = crc16_byte(crc_q, byte_i);

  // Next frame state and result for the item in hand
  always_comb begin
    byte_index_d  = byte_index_q;
    crc_d         = crc_q;
    value_d       = value_q;
    header_good_d = header_good_q;
    crc_low_d     = crc_low_q;
    closed_d      = closed_q;
    res_o         = '{valid: 1'b0, status: ST_OK, value: 32'd0};

    if (step_i) begin
      unique case (req_i)
        REQ_START: begin
          byte_index_d  = '0;
          crc_d         = CRC_INIT;
          value_d       = '0;
          header_good_d = 1'b1;
          crc_low_d     = '0;
          closed_d      = 1'b0;
        end
        REQ_TIMEOUT: begin
          if (!closed_q) begin
            closed_d     = 1'b1;
            res_o.valid  = 1'b1;
            res_o.status = ST_SHORT;
          end
        end
        REQ_BYTE: begin
          if (!closed_q) begin
            byte_index_d = byte_index_q + 4'd1;
            if (!hdr_ok) begin
              header_good_d = 1'b0;
            end
            if (byte_index_q >= IDX_VAL0 && byte_index_q <= IDX_VAL3) begin
              value_d = {value_q[23:0], byte_i};
            end
            if (byte_index_q == IDX_CRC_LO) begin
              crc_low_d = byte_i;
            end
            if (byte_index_q < CRC_SPAN) begin
              crc_d = crc_next;
            end
            // Last byte: report the frame
            if (byte_index_q == IDX_CRC_HI) begin
              closed_d    = 1'b1;
              res_o.valid = 1'b1;
              if (!header_good_q) begin
                res_o.status = ST_HEADER;
              end else if (crc_low_q != crc_q[7:0] || byte_i != crc_q[15:8]) begin
                res_o.status = ST_CRC;
              end else begin
                res_o.status = ST_OK;
                res_o.value  = value_q;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= '0;
      crc_q         <= CRC_INIT;
      value_q       <= '0;
      header_good_q <= 1'b1;
      crc_low_q     <= '0;
      closed_q      <= 1'b0;
    end else begin
      byte_index_q  <= byte_index_d;
      crc_q         <= crc_d;
      value_q       <= value_d;
      header_good_q <= header_good_d;
      crc_low_q     <= crc_low_d;
      closed_q      <= closed_d;
    end
  end

endmodule

### src/modbus_read_response_checker.sv
// Top level of the Modbus-RTU read response checker.
// Depends on mbrc_pkg and mbrc_frame.
//
// Checks a 9-byte read-holding-registers response one byte per transfer and
// reports ok, short frame, bad header or bad CRC together with the 32-bit
// big-endian register value. The block takes one item per cycle while the
// output register can take a result. An item is held in the input register,
// the byte-wide CRC-16 update and frame checks run on it combinationally, and
// a result is loaded into the output register when the item advances. The input
// register can take an item while a result waits in the output register;
// the input side stalls only when both registers are full. The expected
// slave address resets to 1; the user must write it over the configuration
// channel only while the block is idle; the block does not enforce this.
module modbus_read_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_slave_address_i,
  // Input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] lux_raw_o
);
  import mbrc_pkg::*;

  logic [7:0]  slave_addr_q;
  logic        in_valid_q;
  logic [1:0]  req_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] value_q;

  logic        step;
  logic        in_take;
  result_t     res;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= ADDR_RESET;
    end else if (cfg_valid_i) begin
      slave_addr_q <= cfg_slave_address_i;
    end
  end

  // Advance the held item when the output register can take a result
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q  <= req_type_i;
      byte_q <= rx_byte_i;
    end
  end

  mbrc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_i       (req_e'(req_q)),
    .byte_i      (byte_q),
    .slave_addr_i(slave_addr_q),
    .res_o       (res)
  );

  // Output register: load a new result, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      status_q <= res.status;
      value_q  <= res.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign lux_raw_o   = value_q;

endmodule
